@@ hdl/ubxfr_pkg.sv @@
package ubxfr_pkg;

    // Frame sync bytes
    localparam logic [7:0] SYNC_ONE = 8'hB5;
    localparam logic [7:0] SYNC_TWO = 8'h62;

    // Register defaults
    localparam logic [7:0] CLASS_RESET = 8'h01;
    localparam logic [7:0] ID_RESET    = 8'h07;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_CLASS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ID    = 2'd1;

    // Payload size limit and derived counter width
    localparam int MAX_PAYLOAD = 128;
    localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int INDEX_W     = 7;

    // One result beat
    typedef struct packed {
        logic               payload_valid;
        logic [7:0]         payload_byte;
        logic [INDEX_W-1:0] byte_pos;
        logic               frame_end;
        logic               frame_ok;
        logic               length_error;
    } result_t;

    // Configured match bytes
    typedef struct packed {
        logic [7:0] expected_class;
        logic [7:0] expected_id;
    } cfg_t;

endpackage

@@ hdl/ubx_frame_receiver.sv @@
// Channel  | Dir | Handshake               | Payload
// s_       | in  | s_tvalid / s_tready     | s_tdata[7:0] = rx_byte
// m_       | out | m_tvalid / m_tready     | m_tdata = index/byte, m_tlast, m_tuser = flags
// cfg_     | in  | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One result beat per input beat, registered in the output queue when the input beat is taken.
// Throughput is one byte per clock while the output queue has room; the per-byte parser
// update is a single registered step. The two-entry queue lets an input beat be taken while
// a result waits. aresetn is synchronous, active low; registers return to 0x01 / 0x07.
// s_tready drops whenever both queue entries are full, also when m_tready is high.
module ubx_frame_receiver
    import ubxfr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] rx_byte
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,   // [7:0] payload_byte, [14:8] byte_pos, [15] 0
    output logic                 m_tlast,   // frame_end
    output logic [2:0]           m_tuser,   // [0] payload_valid, [1] frame_ok, [2] length_error
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    cfg_t    cfg;
    result_t result;
    result_t head;
    logic    beat_en;
    logic    can_push;

    assign cfg_ready = 1'b1;
    assign s_tready  = can_push;
    assign beat_en   = s_tvalid && can_push;

    ubxfr_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    ubxfr_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .beat_en (beat_en),
        .rx_byte (s_tdata),
        .cfg     (cfg),
        .result  (result)
    );

    ubxfr_out_buf u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (beat_en),
        .push_data (result),
        .can_push  (can_push),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (head)
    );

    // Output packing
    assign m_tdata = {1'b0, head.byte_pos, head.payload_byte};
    assign m_tlast = head.frame_end;
    assign m_tuser = {head.length_error, head.frame_ok, head.payload_valid};

    // A frame end never carries payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> !m_tuser[0])
        else $error("frame end beat flagged as payload");

    // Good frame only on frame end
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> m_tlast)
        else $error("frame_ok outside frame end");

    // Length error never coincides with payload or frame end
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[2]) |-> (!m_tuser[0] && !m_tlast))
        else $error("length error on data or end beat");

    // Non-payload beats carry zero data
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == 16'd0))
        else $error("stray data on non-payload beat");

endmodule

@@ hdl/ubxfr_cfg_regs.sv @@
module ubxfr_cfg_regs
    import ubxfr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [7:0]           wr_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Register decode; unknown indexes are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_index)
                REG_CLASS: cfg_next.expected_class = wr_data;
                REG_ID:    cfg_next.expected_id    = wr_data;
                default:   ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.expected_class <= CLASS_RESET;
            cfg_reg.expected_id    <= ID_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hdl/ubxfr_parser.sv @@
module ubxfr_parser
    import ubxfr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       beat_en,
    input  logic [7:0] rx_byte,
    input  cfg_t       cfg,
    output result_t    result
);

    typedef enum logic [3:0] {
        PH_SYNC1 = 4'd0,
        PH_SYNC2 = 4'd1,
        PH_CLASS = 4'd2,
        PH_ID    = 4'd3,
        PH_LENLO = 4'd4,
        PH_LENHI = 4'd5,
        PH_DATA  = 4'd6,
        PH_CKA   = 4'd7,
        PH_CKB   = 4'd8
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [7:0]       len_lo_reg, len_lo_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] count_reg, count_next;
    logic [7:0]       sum_a_reg, sum_a_next;
    logic [7:0]       sum_b_reg, sum_b_next;
    logic             ck_ok_reg, ck_ok_next;

    logic [15:0]      full_len;
    logic [7:0]       add_a;
    logic [7:0]       add_b;
    logic [LEN_W-1:0] count_inc;
    phase_t           resync;

    // Running Fletcher sums with this byte folded in
    assign add_a     = sum_a_reg + rx_byte;
    assign add_b     = sum_b_reg + add_a;
    assign full_len  = {rx_byte, len_lo_reg};
    assign count_inc = count_reg + LEN_W'(1);
    assign resync    = (rx_byte == SYNC_ONE) ? PH_SYNC2 : PH_SYNC1;

    // Per-byte state update and result
    always_comb begin
        phase_next  = phase_reg;
        len_lo_next = len_lo_reg;
        len_next    = len_reg;
        count_next  = count_reg;
        sum_a_next  = sum_a_reg;
        sum_b_next  = sum_b_reg;
        ck_ok_next  = ck_ok_reg;
        result      = '0;
        unique case (phase_reg)
            PH_SYNC2: begin
                phase_next = (rx_byte == SYNC_TWO) ? PH_CLASS : resync;
            end
            PH_CLASS: begin
                if (rx_byte == cfg.expected_class) begin
                    sum_a_next = rx_byte;
                    sum_b_next = rx_byte;
                    phase_next = PH_ID;
                end else begin
                    phase_next = resync;
                end
            end
            PH_ID: begin
                if (rx_byte == cfg.expected_id) begin
                    sum_a_next = add_a;
                    sum_b_next = add_b;
                    phase_next = PH_LENLO;
                end else begin
                    phase_next = resync;
                end
            end
            PH_LENLO: begin
                sum_a_next  = add_a;
                sum_b_next  = add_b;
                len_lo_next = rx_byte;
                phase_next  = PH_LENHI;
            end
            PH_LENHI: begin
                sum_a_next = add_a;
                sum_b_next = add_b;
                len_next   = full_len[LEN_W-1:0];
                count_next = '0;
                if (full_len > 16'(MAX_PAYLOAD)) begin
                    result.length_error = 1'b1;
                    phase_next          = PH_SYNC1;
                end else if (full_len == 16'd0) begin
                    phase_next = PH_CKA;
                end else begin
                    phase_next = PH_DATA;
                end
            end
            PH_DATA: begin
                sum_a_next             = add_a;
                sum_b_next             = add_b;
                result.payload_valid   = 1'b1;
                result.payload_byte    = rx_byte;
                result.byte_pos        = count_reg[INDEX_W-1:0];
                count_next             = count_inc;
                if (count_inc >= len_reg) begin
                    phase_next = PH_CKA;
                end
            end
            PH_CKA: begin
                ck_ok_next = (rx_byte == sum_a_reg);
                phase_next = PH_CKB;
            end
            PH_CKB: begin
                result.frame_end = 1'b1;
                result.frame_ok  = ck_ok_reg && (rx_byte == sum_b_reg);
                ck_ok_next       = 1'b0;
                phase_next       = PH_SYNC1;
            end
            default: begin
                // first sync byte and unused codes
                phase_next = resync;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_SYNC1;
            len_lo_reg <= '0;
            len_reg    <= '0;
            count_reg  <= '0;
            sum_a_reg  <= '0;
            sum_b_reg  <= '0;
            ck_ok_reg  <= 1'b0;
        end else if (beat_en) begin
            phase_reg  <= phase_next;
            len_lo_reg <= len_lo_next;
            len_reg    <= len_next;
            count_reg  <= count_next;
            sum_a_reg  <= sum_a_next;
            sum_b_reg  <= sum_b_next;
            ck_ok_reg  <= ck_ok_next;
        end
    end

endmodule

@@ hdl/ubxfr_out_buf.sv @@
module ubxfr_out_buf
    import ubxfr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  result_t push_data,
    output logic    can_push,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    // Two-entry circular result queue with read and write pointers
    result_t    entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign can_push  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ bench/tb_ubx_frame_receiver.sv @@
module tb_ubx_frame_receiver;
    import ubxfr_pkg::*;

    // Writes to these indexes hit no register and must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 2'd3;

    typedef enum logic [3:0] {
        PH_HUNT,
        PH_WAIT_SYNC2,
        PH_WAIT_CLASS,
        PH_WAIT_ID,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_PAYLOAD,
        PH_CHECK_A,
        PH_CHECK_B
    } parse_phase_t;

    // Ways a generated frame can be damaged
    typedef enum {
        FLAW_NONE,
        FLAW_CHECK_A,
        FLAW_CHECK_B,
        FLAW_CLASS,
        FLAW_ID,
        FLAW_CUT
    } frame_flaw_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;     // [7:0] rx_byte
    logic                 m_tvalid;
    logic                 m_tready;
    logic [15:0]          m_tdata;     // [7:0] payload_byte, [14:8] byte_pos
    logic                 m_tlast;     // frame_end
    logic [2:0]           m_tuser;     // [0] payload_valid, [1] frame_ok, [2] length_error
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_data;

    ubx_frame_receiver u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Parser mirror: match bytes, phase, length, count, Fletcher sums
    logic [7:0]   match_class;
    logic [7:0]   match_id;
    parse_phase_t rx_phase;
    logic [15:0]  frame_len;
    logic [15:0]  payload_count;
    logic [7:0]   fletcher_a;
    logic [7:0]   fletcher_b;
    bit           first_check_ok;

    result_t parser_outputs[$];
    int          mismatch_count;
    int          beat_count;
    int          rx_sent;
    bit          stall_enable;
    bit          gaps_enable;
    int          ready_hold;

    function automatic void reset_parser_model();
        match_class    = CLASS_RESET;
        match_id       = ID_RESET;
        rx_phase       = PH_HUNT;
        frame_len      = '0;
        payload_count  = '0;
        fletcher_a     = '0;
        fletcher_b     = '0;
        first_check_ok = 1'b0;
    endfunction

    function automatic void fold_into_sums(input logic [7:0] b);
        fletcher_a = fletcher_a + b;
        fletcher_b = fletcher_b + fletcher_a;
    endfunction

    // A mismatching byte of B5 may start the next frame
    function automatic parse_phase_t restart_phase(input logic [7:0] b);
        return (b == SYNC_ONE) ? PH_WAIT_SYNC2 : PH_HUNT;
    endfunction

    function automatic result_t parse_rx_byte(input logic [7:0] b);
        result_t r;
        r = '0;
        case (rx_phase)
            PH_WAIT_SYNC2: begin
                rx_phase = (b == SYNC_TWO) ? PH_WAIT_CLASS : restart_phase(b);
            end
            PH_WAIT_CLASS: begin
                if (b == match_class) begin
                    fletcher_a = '0;
                    fletcher_b = '0;
                    fold_into_sums(b);
                    rx_phase = PH_WAIT_ID;
                end else begin
                    rx_phase = restart_phase(b);
                end
            end
            PH_WAIT_ID: begin
                if (b == match_id) begin
                    fold_into_sums(b);
                    rx_phase = PH_LEN_LO;
                end else begin
                    rx_phase = restart_phase(b);
                end
            end
            PH_LEN_LO: begin
                fold_into_sums(b);
                frame_len = {8'h00, b};
                rx_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                fold_into_sums(b);
                frame_len[15:8] = b;
                payload_count = '0;
                if (frame_len > MAX_PAYLOAD) begin
                    r.length_error = 1'b1;
                    rx_phase = PH_HUNT;
                end else if (frame_len == 0) begin
                    rx_phase = PH_CHECK_A;
                end else begin
                    rx_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                fold_into_sums(b);
                r.payload_valid = 1'b1;
                r.payload_byte  = b;
                r.byte_pos      = payload_count[INDEX_W-1:0];
                payload_count = payload_count + 16'd1;
                if (payload_count >= frame_len)
                    rx_phase = PH_CHECK_A;
            end
            PH_CHECK_A: begin
                first_check_ok = (b == fletcher_a);
                rx_phase = PH_CHECK_B;
            end
            PH_CHECK_B: begin
                r.frame_end = 1'b1;
                r.frame_ok  = first_check_ok && (b == fletcher_b);
                first_check_ok = 1'b0;
                rx_phase = PH_HUNT;
            end
            default: begin
                rx_phase = restart_phase(b);
            end
        endcase
        return r;
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [7:0] data);
        if (idx == REG_CLASS)
            match_class = data;
        else if (idx == REG_ID)
            match_id = data;
    endfunction

    // Idle lengths: mostly short, now and then long
    function automatic int pick_idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(1, 3);
        else if (r < 92)
            return $urandom_range(4, 9);
        return $urandom_range(20, 50);
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("beat %0d: %s", beat_count, msg);
    endtask

    task automatic compare_field(input string field, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
            report_mismatch($sformatf("%s expected %0h, got %0h", field, want, got));
    endtask

    // Result side: values at the falling edge hold through the next rising edge
    always @(negedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (parser_outputs.size() == 0) begin
                report_mismatch("result beat with nothing expected");
            end else begin
                want = parser_outputs.pop_front();
                compare_field("payload_byte",  want.payload_byte,  m_tdata[7:0]);
                compare_field("byte_pos",      want.byte_pos,      m_tdata[14:8]);
                compare_field("frame_end",     want.frame_end,     m_tlast);
                compare_field("payload_valid", want.payload_valid, m_tuser[0]);
                compare_field("frame_ok",      want.frame_ok,      m_tuser[1]);
                compare_field("length_error",  want.length_error,  m_tuser[2]);
            end
            beat_count++;
        end
    end

    // Receiver back-pressure
    always @(posedge aclk) begin
        if (!stall_enable) begin
            m_tready <= 1'b1;
        end else if (ready_hold == 0) begin
            if ($urandom_range(0, 1)) begin
                m_tready <= 1'b1;
                ready_hold = $urandom_range(1, 12);
            end else begin
                m_tready <= 1'b0;
                ready_hold = pick_idle_len();
            end
        end else begin
            ready_hold--;
        end
    end

    // One input beat; expectation is recorded when the handshake is certain
    task automatic send_rx_byte(input logic [7:0] b);
        int gap;
        gap = (gaps_enable && $urandom_range(0, 2) == 0) ? pick_idle_len() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        parser_outputs.push_back(parse_rx_byte(b));
        rx_sent++;
        @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge aclk);
        while (!cfg_ready) @(negedge aclk);
        apply_register(idx, data);
        @(posedge aclk);
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        while (parser_outputs.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic program_match(input logic [7:0] cls, input logic [7:0] id);
        wait_for_drain();
        write_register(REG_CLASS, cls);
        write_register(REG_ID, id);
        cfg_valid <= 1'b0;
    endtask

    // Builds a frame with correct sums, then damages it as asked
    task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                              input logic [15:0] len, input frame_flaw_t flaw,
                              input bit extremes_fill);
        logic [7:0] stream[$];
        logic [7:0] ck_a;
        logic [7:0] ck_b;
        logic [7:0] pb;
        int         keep;
        ck_a = '0;
        ck_b = '0;
        stream = '{SYNC_ONE, SYNC_TWO, cls, id, len[7:0], len[15:8]};
        for (int i = 2; i < 6; i++) begin
            ck_a = ck_a + stream[i];
            ck_b = ck_b + ck_a;
        end
        if (len <= MAX_PAYLOAD) begin
            for (int i = 0; i < len; i++) begin
                if (extremes_fill)
                    pb = i[0] ? 8'hFF : 8'h00;
                else if ($urandom_range(0, 15) == 0)
                    pb = SYNC_ONE;
                else
                    pb = 8'($urandom_range(0, 255));
                stream.push_back(pb);
                ck_a = ck_a + pb;
                ck_b = ck_b + ck_a;
            end
            stream.push_back(ck_a);
            stream.push_back(ck_b);
        end
        case (flaw)
            FLAW_CHECK_A: if (len <= MAX_PAYLOAD)
                stream[stream.size() - 2] ^= 8'($urandom_range(1, 255));
            FLAW_CHECK_B: if (len <= MAX_PAYLOAD)
                stream[stream.size() - 1] ^= 8'($urandom_range(1, 255));
            FLAW_CLASS: stream[2] ^= 8'($urandom_range(1, 255));
            FLAW_ID:    stream[3] ^= 8'($urandom_range(1, 255));
            FLAW_CUT: begin
                keep = $urandom_range(1, stream.size() - 1);
                while (stream.size() > keep) void'(stream.pop_back());
            end
            default: ;
        endcase
        foreach (stream[i]) send_rx_byte(stream[i]);
    endtask

    // Defaults after reset: sync restart, zero length, bad first check, too long
    task automatic test_directed_frames();
        send_rx_byte(SYNC_ONE);
        send_frame(CLASS_RESET, ID_RESET, 16'd0, FLAW_NONE, 1'b0);
        send_rx_byte(SYNC_ONE);
        send_rx_byte(SYNC_TWO);
        send_frame(CLASS_RESET, ID_RESET, 16'd2, FLAW_CHECK_A, 1'b1);
        send_frame(CLASS_RESET, ID_RESET, 16'd129, FLAW_NONE, 1'b0);
    endtask

    // Match bytes at their extremes and equal to the sync bytes; writes to unused indexes
    task automatic test_register_settings();
        program_match(8'h00, 8'hFF);
        send_frame(match_class, match_id, 16'd3, FLAW_NONE, 1'b1);
        send_frame(match_class, match_id, 16'd1, FLAW_ID, 1'b0);
        program_match(8'hFF, 8'h00);
        send_frame(match_class, match_id, 16'd2, FLAW_NONE, 1'b0);
        send_frame(match_class, match_id, 16'd2, FLAW_CLASS, 1'b0);
        wait_for_drain();
        write_register(REG_UNUSED_A, 8'($urandom_range(0, 255)));
        write_register(REG_UNUSED_B, 8'($urandom_range(0, 255)));
        cfg_valid <= 1'b0;
        send_frame(match_class, match_id, 16'd1, FLAW_NONE, 1'b0);
        program_match(SYNC_ONE, SYNC_TWO);
        send_frame(match_class, match_id, 16'd4, FLAW_NONE, 1'b0);
        send_frame(match_class, match_id, 16'd0, FLAW_CHECK_B, 1'b0);
    endtask

    // Longest legal payload and lengths just and far above it
    task automatic test_long_frames();
        program_match(CLASS_RESET, ID_RESET);
        send_frame(match_class, match_id, 16'(MAX_PAYLOAD), FLAW_NONE, 1'b0);
        send_frame(match_class, match_id, 16'(MAX_PAYLOAD + 1), FLAW_NONE, 1'b0);
        send_frame(match_class, match_id, 16'h0100, FLAW_NONE, 1'b0);
        send_frame(match_class, match_id, 16'hFFFF, FLAW_NONE, 1'b0);
    endtask

    // Mostly well-formed frames with random content, some damage and line noise
    task automatic test_random_traffic();
        int          phase_end;
        int          r;
        logic [15:0] len;
        frame_flaw_t flaw;
        for (int ph = 0; ph < 4; ph++) begin
            if (ph == 2)
                program_match(CLASS_RESET, ID_RESET);
            else
                program_match(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            stall_enable = (ph == 1) || (ph == 2);
            gaps_enable  = (ph == 1) || (ph == 3);
            phase_end = rx_sent + 80;
            while (rx_sent < phase_end) begin
                if ($urandom_range(0, 99) < 75) begin
                    r = $urandom_range(0, 99);
                    if (r < 85)
                        len = 16'($urandom_range(0, 12));
                    else if (r < 95)
                        len = 16'($urandom_range(13, 60));
                    else if (r < 97)
                        len = 16'($urandom_range(120, MAX_PAYLOAD));
                    else
                        len = 16'($urandom_range(MAX_PAYLOAD + 1, 16'hFFFF));
                    r = $urandom_range(0, 99);
                    if (r < 60)      flaw = FLAW_NONE;
                    else if (r < 70) flaw = FLAW_CHECK_A;
                    else if (r < 78) flaw = FLAW_CHECK_B;
                    else if (r < 85) flaw = FLAW_CLASS;
                    else if (r < 92) flaw = FLAW_ID;
                    else             flaw = FLAW_CUT;
                    send_frame(match_class, match_id, len, flaw, 1'b0);
                end else begin
                    repeat ($urandom_range(1, 6)) begin
                        r = $urandom_range(0, 9);
                        case (r)
                            0: send_rx_byte(SYNC_ONE);
                            1: send_rx_byte(SYNC_TWO);
                            2: send_rx_byte(match_class);
                            default: send_rx_byte(8'($urandom_range(0, 255)));
                        endcase
                    end
                end
            end
        end
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        m_tready  <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_CLASS;
        cfg_data  <= '0;
        reset_parser_model();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_frames();
        test_register_settings();
        test_long_frames();
        test_random_traffic();

        stall_enable = 1'b0;
        wait_for_drain();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && parser_outputs.size() == 0)
            $display("[ubx_frame_receiver] OK");
        else
            $display("[ubx_frame_receiver] ERROR");
        $finish;
    end

    // Run limit
    initial begin
        #5000000;
        $display("[ubx_frame_receiver] ERROR");
        $finish;
    end

endmodule
